>>> design/emsp_pkg.sv
`default_nettype none
package emsp_pkg;

    localparam int DataW      = 32;
    localparam int DecayW     = 17;
    localparam int StepW      = 24;
    localparam int TurnW      = 19;
    localparam int AngW       = 32;
    localparam int CordW      = 34;
    localparam int TableLen   = 24;
    localparam int CordicIterDefault = 16;
    localparam logic [DecayW-1:0] DecayReset = 17'd62915;
    localparam logic signed [AngW-1:0] AngPi     = 32'sd843314857;
    localparam logic signed [AngW-1:0] AngHalfPi = 32'sd421657428;
    localparam logic signed [CordW-1:0] CordGain = 34'sd652032874;

    localparam logic [0:0] RegDecay = 1'b0;

    typedef logic signed [DataW-1:0] data_t;

    // arctangent table in q3.28
    function automatic logic signed [AngW-1:0] atan_q28(input int idx);
        logic signed [AngW-1:0] r;
        begin
            case (idx)
                0: r = 32'sd210828714;
                1: r = 32'sd124459457;
                2: r = 32'sd65760959;
                3: r = 32'sd33381290;
                4: r = 32'sd16755422;
                5: r = 32'sd8385879;
                6: r = 32'sd4193963;
                7: r = 32'sd2097109;
                8: r = 32'sd1048571;
                9: r = 32'sd524287;
                default: r = (idx < TableLen) ? (32'sd262144 >>> (idx - 10)) : 32'sd0;
            endcase
            return r;
        end
    endfunction

    // saturate a wide signed value to 32 bits
    function automatic data_t sat32(input logic signed [79:0] v);
        data_t r;
        begin
            if (v > 80'sd2147483647)
                r = 32'sh7fffffff;
            else if (v < -80'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[DataW-1:0];
            return r;
        end
    endfunction

    // round half up by 16 bits, then saturate
    function automatic data_t rnd16_sat(input logic signed [79:0] v);
        logic signed [79:0] t;
        begin
            t = (v + 80'sd32768) >>> 16;
            return sat32(t);
        end
    endfunction

    typedef struct packed {
        data_t px;
        data_t py;
        data_t vx;
        data_t vy;
        data_t dx;
        data_t dy;
    } state_t;

endpackage
`default_nettype wire

>>> design/ego_motion_state_predict.sv
// CORDIC_ITERATIONS is limited to 24 (TableLen)
// throughput: one request per cycle unless the output stalls, set by the fully pipelined cordic and multipliers
// a stalled output holds the whole pipeline; the input is ready whenever the
// output is taken or the pipeline has room at its last stage
// reset: valid bits clear, velocity_decay returns to 0.96
`default_nettype none
module ego_motion_state_predict #(
    parameter int CORDIC_ITERATIONS = emsp_pkg::CordicIterDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic signed [31:0] pos_x_in,
    input  wire logic signed [31:0] pos_y_in,
    input  wire logic signed [31:0] vel_x_in,
    input  wire logic signed [31:0] vel_y_in,
    input  wire logic [23:0] time_step,
    input  wire logic signed [31:0] odo_dx,
    input  wire logic signed [31:0] odo_dy,
    input  wire logic signed [18:0] odo_turn,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] pos_x_out,
    output logic signed [31:0] pos_y_out,
    output logic signed [31:0] vel_x_out,
    output logic signed [31:0] vel_y_out
);
    import emsp_pkg::*;

    localparam int N   = (CORDIC_ITERATIONS > TableLen) ? TableLen : CORDIC_ITERATIONS;
    localparam int Lat = N + 3;

    logic [DecayW-1:0] decay_reg;
    logic [Lat-1:0]    vld_reg;
    logic              en;
    state_t            s_in, s_front, s_mid_reg [N-1];
    data_t             c, s;
    data_t             px, py, vx, vy;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == {RegDecay, 1'b0}) ? {15'd0, decay_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decay_reg <= DecayReset;
        else if (psel && penable && pwrite && paddr[1:0] == {RegDecay, 1'b0})
            decay_reg <= pwdata[DecayW-1:0];
    end

    // pipeline advances unless the result is held
    assign en       = !out_valid || out_ready;
    assign in_ready = en;
    assign out_valid = vld_reg[Lat-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[Lat-2:0], in_valid};
    end

    assign s_in = '{px: pos_x_in, py: pos_y_in, vx: vel_x_in, vy: vel_y_in,
                    dx: odo_dx, dy: odo_dy};

    emsp_front u_front (
        .clk(clk), .en(en), .s_in(s_in), .time_step(time_step),
        .decay(decay_reg), .s_out(s_front)
    );

    emsp_cordic #(.Iterations(N)) u_cordic (
        .clk(clk), .en(en), .turn(odo_turn),
        .cos_q16(c), .sin_q16(s)
    );

    // delay the state to meet the cordic output
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_mid_reg[0] <= s_front;
            for (int k = 1; k < N - 1; k++)
                s_mid_reg[k] <= s_mid_reg[k-1];
        end
    end

    emsp_rotate u_rot (
        .clk(clk), .en(en), .s_in(s_mid_reg[N-2]), .c(c), .s(s),
        .px(px), .py(py), .vx(vx), .vy(vy)
    );

    assign pos_x_out = px;
    assign pos_y_out = py;
    assign vel_x_out = vx;
    assign vel_y_out = vy;
endmodule
`default_nettype wire

>>> design/emsp_cordic.sv
`default_nettype none
module emsp_cordic #(
    parameter int Iterations = emsp_pkg::CordicIterDefault
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic signed [emsp_pkg::TurnW-1:0] turn,
    output logic signed [emsp_pkg::DataW-1:0] cos_q16,
    output logic signed [emsp_pkg::DataW-1:0] sin_q16
);
    import emsp_pkg::*;

    localparam int N = (Iterations > TableLen) ? TableLen : Iterations;

    logic signed [CordW-1:0] x_reg [N+1];
    logic signed [CordW-1:0] y_reg [N+1];
    logic signed [AngW-1:0]  z_reg [N+1];
    logic                    f_reg [N+1];
    logic signed [AngW-1:0]  z0;
    logic signed [CordW-1:0] xr;
    logic signed [CordW-1:0] yr;

    // quadrant fold into plus or minus pi/2
    always_comb
    begin
        z0 = {{(AngW-TurnW-12){turn[TurnW-1]}}, turn, 12'd0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= CordGain;
            y_reg[0] <= '0;
            if (z0 > AngHalfPi)
            begin
                z_reg[0] <= z0 - AngPi;
                f_reg[0] <= 1'b1;
            end
            else if (z0 < -AngHalfPi)
            begin
                z_reg[0] <= z0 + AngPi;
                f_reg[0] <= 1'b1;
            end
            else
            begin
                z_reg[0] <= z0;
                f_reg[0] <= 1'b0;
            end
        end
    end

    // one rotation step per stage
    for (genvar i = 0; i < N; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                f_reg[i+1] <= f_reg[i];
                if (!z_reg[i][AngW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q28(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q28(i);
                end
            end
        end
    end

    // round to q16 and undo the fold
    always_comb
    begin
        xr = (x_reg[N] + 34'sd8192) >>> 14;
        yr = (y_reg[N] + 34'sd8192) >>> 14;
        if (f_reg[N])
        begin
            xr = -xr;
            yr = -yr;
        end
        cos_q16 = xr[DataW-1:0];
        sin_q16 = yr[DataW-1:0];
    end
endmodule
`default_nettype wire

>>> design/emsp_front.sv
`default_nettype none
module emsp_front (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire emsp_pkg::state_t              s_in,
    input  wire logic [emsp_pkg::StepW-1:0]    time_step,
    input  wire logic [emsp_pkg::DecayW-1:0]   decay,
    output emsp_pkg::state_t                   s_out
);
    import emsp_pkg::*;

    logic signed [56:0] mpx_reg, mpy_reg, mvx_reg, mvy_reg;
    state_t s1_reg;
    state_t s2_reg;

    // products of the advance and the decay
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mpx_reg <= 57'(s_in.vx * $signed({1'b0, time_step}));
            mpy_reg <= 57'(s_in.vy * $signed({1'b0, time_step}));
            mvx_reg <= 57'(s_in.vx * $signed({1'b0, decay}));
            mvy_reg <= 57'(s_in.vy * $signed({1'b0, decay}));
            s1_reg  <= s_in;
        end
    end

    // round, add and saturate
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg.dx <= s1_reg.dx;
            s2_reg.dy <= s1_reg.dy;
            s2_reg.px <= sat32(80'(s1_reg.px) + ((80'(mpx_reg) + 80'sd32768) >>> 16));
            s2_reg.py <= sat32(80'(s1_reg.py) + ((80'(mpy_reg) + 80'sd32768) >>> 16));
            s2_reg.vx <= rnd16_sat(80'(mvx_reg));
            s2_reg.vy <= rnd16_sat(80'(mvy_reg));
        end
    end

    assign s_out = s2_reg;
endmodule
`default_nettype wire

>>> design/emsp_rotate.sv
`default_nettype none
module emsp_rotate (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire emsp_pkg::state_t         s_in,
    input  wire emsp_pkg::data_t          c,
    input  wire emsp_pkg::data_t          s,
    output emsp_pkg::data_t               px,
    output emsp_pkg::data_t               py,
    output emsp_pkg::data_t               vx,
    output emsp_pkg::data_t               vy
);
    import emsp_pkg::*;

    logic signed [63:0] p_reg [8];
    data_t dx1_reg, dy1_reg;
    data_t rx_reg, ry_reg, dx2_reg, dy2_reg, ox_reg, oy_reg;

    // eight products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= s_in.px * c;
            p_reg[1] <= s_in.py * s;
            p_reg[2] <= s_in.py * c;
            p_reg[3] <= s_in.px * s;
            p_reg[4] <= s_in.vx * c;
            p_reg[5] <= s_in.vy * s;
            p_reg[6] <= s_in.vx * s;
            p_reg[7] <= s_in.vy * c;
            dx1_reg  <= s_in.dx;
            dy1_reg  <= s_in.dy;
        end
    end

    // sums, rounding, saturation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg  <= rnd16_sat(80'(p_reg[0]) + 80'(p_reg[1]));
            ry_reg  <= rnd16_sat(80'(p_reg[2]) - 80'(p_reg[3]));
            ox_reg  <= rnd16_sat(80'(p_reg[4]) - 80'(p_reg[5]));
            oy_reg  <= rnd16_sat(80'(p_reg[6]) + 80'(p_reg[7]));
            dx2_reg <= dx1_reg;
            dy2_reg <= dy1_reg;
        end
    end

    // odometry translation
    always_comb
    begin
        px = sat32(80'(rx_reg) - 80'(dx2_reg));
        py = sat32(80'(ry_reg) - 80'(dy2_reg));
        vx = ox_reg;
        vy = oy_reg;
    end
endmodule
`default_nettype wire

>>> design/emsp_checker.sv
`default_nettype none
module emsp_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic pready,
    input wire logic [31:0] pos_x_out
);
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
    a_ready_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready) else $error("input stalled while output taken");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x_out))
        else $error("result dropped");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready) else $error("accept during stall");
endmodule

bind ego_motion_state_predict emsp_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .pready(pready),
    .pos_x_out(pos_x_out)
);
`default_nettype wire

>>> dv/ego_motion_state_predict_checker.sv
`default_nettype none
module ego_motion_state_predict_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic signed [31:0] pos_x_in,
    input  wire logic signed [31:0] pos_y_in,
    input  wire logic signed [31:0] vel_x_in,
    input  wire logic signed [31:0] vel_y_in,
    input  wire logic [23:0] time_step,
    input  wire logic signed [31:0] odo_dx,
    input  wire logic signed [31:0] odo_dy,
    input  wire logic signed [18:0] odo_turn,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic signed [31:0] pos_x_out,
    input  wire logic signed [31:0] pos_y_out,
    input  wire logic signed [31:0] vel_x_out,
    input  wire logic signed [31:0] vel_y_out,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import emsp_pkg::*;

    localparam int Iters = (CordicIterDefault > TableLen) ? TableLen : CordicIterDefault;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } motion_t;

    logic [16:0] decay_q;
    motion_t     predicted_q[$];

    // round half up by a shift, wide signed
    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // cordic sine and cosine in q.16 with quadrant fold
    function automatic void turn_sin_cos(input longint turn, output longint c,
                                         output longint s);
        longint z, x, y, nx, ny;
        bit flip;
        z = turn * 4096;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 421657428)
        begin
            z -= 843314857;
            flip = 1;
        end
        else if (z < -421657428)
        begin
            z += 843314857;
            flip = 1;
        end
        for (int i = 0; i < Iters; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= longint'(atan_q28(i));
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += longint'(atan_q28(i));
            end
            x = nx;
            y = ny;
        end
        c = rnd_shift(x, 14);
        s = rnd_shift(y, 14);
        if (flip)
        begin
            c = -c;
            s = -s;
        end
    endfunction

    function automatic motion_t predict_motion(input longint px, input longint py,
        input longint vx, input longint vy, input longint dt, input longint dx,
        input longint dy, input longint turn, input longint dec);
        motion_t r;
        longint c, s, rx, ry;
        px = clip32(px + rnd_shift(dt * vx, 16));
        py = clip32(py + rnd_shift(dt * vy, 16));
        vx = clip32(rnd_shift(vx * dec, 16));
        vy = clip32(rnd_shift(vy * dec, 16));
        turn_sin_cos(turn, c, s);
        rx = clip32(rnd_shift(px * c + py * s, 16));
        ry = clip32(rnd_shift(py * c - px * s, 16));
        r.px = 32'(clip32(rx - dx));
        r.py = 32'(clip32(ry - dy));
        r.vx = 32'(clip32(rnd_shift(vx * c - vy * s, 16)));
        r.vy = 32'(clip32(rnd_shift(vx * s + vy * c, 16)));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    assign pending = predicted_q.size();

    // register shadow, request prediction and result comparison
    always @(posedge clk or negedge rst_n)
    begin
        motion_t w;
        if (!rst_n)
        begin
            decay_q <= DecayReset;
            predicted_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'(4 * RegDecay))
                decay_q <= pwdata[16:0];
            if (in_valid && in_ready)
                predicted_q.push_back(predict_motion(pos_x_in, pos_y_in, vel_x_in,
                    vel_y_in, longint'(time_step), odo_dx, odo_dy, odo_turn,
                    longint'(decay_q)));
            if (out_valid && out_ready)
            begin
                if (predicted_q.size() == 0)
                begin
                    $display("unexpected result at %0t", $time);
                    fail_count++;
                end
                else
                begin
                    w = predicted_q.pop_front();
                    if (pos_x_out !== w.px) report_mismatch("pos_x", pos_x_out, w.px);
                    if (pos_y_out !== w.py) report_mismatch("pos_y", pos_y_out, w.py);
                    if (vel_x_out !== w.vx) report_mismatch("vel_x", vel_x_out, w.vx);
                    if (vel_y_out !== w.vy) report_mismatch("vel_y", vel_y_out, w.vy);
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> dv/ego_motion_state_predict_test.sv
`default_nettype none
module ego_motion_state_predict_test;
    timeunit 1ns;
    timeprecision 1ps;

    import emsp_pkg::*;

    localparam int Latency = 40;

    logic clk, rst_n;
    logic psel, penable, pwrite, pready;
    logic [1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [31:0] pos_x_in, pos_y_in, vel_x_in, vel_y_in, odo_dx, odo_dy;
    logic [23:0] time_step;
    logic signed [18:0] odo_turn;
    logic signed [31:0] pos_x_out, pos_y_out, vel_x_out, vel_y_out;
    int fail_count, pending, idle_cycles;
    bit hold_off, stall_long;

    ego_motion_state_predict u_top (.*);

    ego_motion_state_predict_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("ego_motion_state_predict_test NOT OK");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            if (stall_long)
            begin
                out_ready <= 0;
                repeat (200) @(negedge clk);
                stall_long = 0;
            end
            else if (hold_off)
                out_ready <= 1;
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic write_decay(input logic [16:0] v);
        @(negedge clk);
        psel <= 1;
        pwrite <= 1;
        paddr <= 2'(4 * RegDecay);
        pwdata <= 32'(v);
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
        repeat (Latency) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_data();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'(signed'(int'($urandom_range(0, 400000))) - 200000);
            3: return 32'(signed'(int'($urandom_range(0, 40000000))) - 20000000);
            default: return $urandom;
        endcase
    endfunction

    // offer one request and hold it until taken
    task automatic send_request(input logic [31:0] px, py, vx, vy, input logic [23:0] dt,
                                input logic [31:0] dx, dy, input logic [18:0] tn);
        pos_x_in <= px;
        pos_y_in <= py;
        vel_x_in <= vx;
        vel_y_in <= vy;
        time_step <= dt;
        odo_dx <= dx;
        odo_dy <= dy;
        odo_turn <= tn;
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(input int n);
        int burst;
        logic [18:0] tn;
        for (int i = 0; i < n; i++)
        begin
            if (burst == 0)
            begin
                in_valid <= 0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
                burst = $urandom_range(1, 20);
            end
            burst--;
            tn = ($urandom_range(0, 7) == 0) ? 19'($urandom) :
                 19'(signed'(int'($urandom_range(0, 411774))) - 205887);
            send_request(rand_data(), rand_data(), rand_data(), rand_data(),
                         ($urandom_range(0, 3) == 0) ? 24'($urandom) :
                         24'($urandom_range(0, 200000)),
                         rand_data(), rand_data(), tn);
        end
        in_valid <= 0;
    endtask

    initial
    begin
        logic [18:0] turns[10];
        turns = '{19'sd0, 19'sd205887, -19'sd205887, 19'sd102944, -19'sd102944,
                  19'sd102943, 19'h3ffff, 19'h40000, 19'sd1, -19'sd1};
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_valid = 0; pos_x_in = 0; pos_y_in = 0; vel_x_in = 0; vel_y_in = 0;
        time_step = 0; odo_dx = 0; odo_dy = 0; odo_turn = 0;
        hold_off = 0; stall_long = 0;
        repeat (11) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: field extremes, turn fold boundaries, saturation
        foreach (turns[i])
            send_request(32'sd65536 * i, -32'sd65536 * i, 32'h00100000, 32'hfff00000,
                         24'd65536, 32'sd1000, -32'sd1000, turns[i]);
        send_request(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     24'hffffff, 32'h80000000, 32'h80000000, 19'sd0);
        send_request(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                     24'hffffff, 32'h7fffffff, 32'h7fffffff, 19'sd205887);
        send_request(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555,
                     24'h555555, 32'haaaaaaaa, 32'h55555555, 19'h2aaaa);
        send_request(32'haaaaaaaa, 32'h55555555, 32'h55555555, 32'haaaaaaaa,
                     24'haaaaaa, 32'h55555555, 32'haaaaaaaa, 19'h55555);
        send_request(0, 0, 0, 0, 0, 0, 0, 0);
        in_valid <= 0;
        wait_drained();

        // random phases over decay settings, extremes included
        write_decay(17'd0);
        send_random(80);
        wait_drained();
        write_decay(17'd65536);
        send_random(80);
        wait_drained();
        write_decay(17'h1ffff);
        send_random(80);
        wait_drained();

        // long receiver hold-off while requests keep coming
        write_decay(17'($urandom));
        stall_long = 1;
        send_random(120);
        wait_drained();

        // output always ready, then the random stall pattern again
        hold_off = 1;
        write_decay(17'd62915);
        send_random(100);
        hold_off = 0;
        send_random(100);
        wait_drained();

        if (fail_count == 0)
            $display("ego_motion_state_predict_test OK");
        else
            $display("ego_motion_state_predict_test NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
